@@ rtl/kvt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the chained hash key-value table.
// No dependencies; imported by every module of the block.
package kvt_pkg;

  localparam int unsigned BUCKET_W   = 8;
  localparam int unsigned KEY_FW     = 32;
  localparam int unsigned VALUE_FW   = 32;
  localparam int unsigned COUNT_FW   = 12;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned COUNT_MAX  = 4095;

  typedef enum logic [1:0] {
    KVT_INSERT = 2'd0,
    KVT_FIND   = 2'd1,
    KVT_REMOVE = 2'd2
  } kvt_cmd_e;

  typedef enum logic [1:0] {
    KVT_OK      = 2'd0,
    KVT_PRESENT = 2'd1,
    KVT_MISSING = 2'd2,
    KVT_FULL    = 2'd3
  } kvt_status_e;

  typedef enum logic [1:0] {
    KVT_CLEAR  = 2'd0,
    KVT_IDLE   = 2'd1,
    KVT_UPDATE = 2'd2
  } kvt_state_e;

  typedef struct packed {
    logic        wr_en;
    logic        count_inc;
    logic        count_dec;
    kvt_status_e status;
  } kvt_decision_t;

endpackage

@@ rtl/chained_hash_key_value_table_top.sv @@
`timescale 1ns / 1ps
// A new request is taken only in KVT_IDLE and not while a result waits on m_axis_tready;
// each takes a read-modify-write of one bucket row in the row memory (read on accept,
// compare and write back in the following cycle), and its result is registered on m_axis.
// Reset: rst_ni clears control state, then a clearing pass empties every bucket row in
// turn; no request is accepted until it completes.
module chained_hash_key_value_table_top import kvt_pkg::*; #(
  parameter int unsigned BUCKETS     = 256,
  parameter int unsigned WAYS        = 8,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // bucket [7:0], key [39:8], value [71:40]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // command [1:0]
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // found_value [31:0], entry_count [43:32], is_empty [44], zero [47:45]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status [1:0]
  output logic [1:0]            m_axis_tuser
);

  localparam int unsigned ROW_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned ROW_BITS = WAYS * (1 + KEY_WIDTH + VALUE_WIDTH);
  localparam int unsigned CNT_W    = $clog2(BUCKETS * WAYS + 1);
  localparam int unsigned LUT_N    = 1 << BUCKET_W;

  kvt_state_e             state_q, state_d;
  logic [ROW_W-1:0]       clr_q, clr_d;
  logic [CNT_W-1:0]       count_q, count_d;
  kvt_cmd_e               cmd_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [ROW_W-1:0]       row_q;
  logic                   m_valid_q;
  kvt_status_e            out_status_q;
  logic [VALUE_FW-1:0]    out_found_q;
  logic [COUNT_FW-1:0]    out_count_q;
  logic                   out_empty_q;

  logic [ROW_W-1:0]       row_lut [LUT_N];
  logic [ROW_W-1:0]       in_row;
  logic                   accept;
  logic                   load_out;
  logic                   mem_wr_en;
  logic [ROW_W-1:0]       mem_wr_addr;
  logic [ROW_BITS-1:0]    mem_wr_data;
  logic [ROW_BITS-1:0]    rd_row;
  logic [ROW_BITS-1:0]    new_row;
  logic [VALUE_FW-1:0]    found;
  kvt_decision_t          dec;
  logic [COUNT_FW-1:0]    count_sat;

  for (genvar i = 0; i < LUT_N; i++) begin : g_row_lut
    assign row_lut[i] = ROW_W'(i % BUCKETS);
  end

  assign in_row = row_lut[s_axis_tdata[BUCKET_W-1:0]];
  assign accept = s_axis_tvalid && s_axis_tready;

  kvt_row_mem #(
    .DEPTH  (BUCKETS),
    .ADDR_W (ROW_W),
    .WIDTH  (ROW_BITS)
  ) u_row_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (in_row),
    .rd_data_o (rd_row),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  kvt_bucket_logic #(
    .WAYS        (WAYS),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .ROW_BITS    (ROW_BITS)
  ) u_bucket_logic (
    .cmd_i   (cmd_q),
    .key_i   (key_q),
    .value_i (value_q),
    .row_i   (rd_row),
    .row_o   (new_row),
    .found_o (found),
    .dec_o   (dec)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      KVT_CLEAR: begin
        if (clr_q == ROW_W'(BUCKETS - 1)) begin
          state_d = KVT_IDLE;
        end
      end
      KVT_IDLE: begin
        if (accept) begin
          state_d = KVT_UPDATE;
        end
      end
      KVT_UPDATE: begin
        state_d = KVT_IDLE;
      end
      default: begin
        state_d = KVT_CLEAR;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = row_q;
    mem_wr_data   = new_row;
    clr_d         = clr_q;
    unique case (state_q)
      KVT_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_q;
        mem_wr_data = '0;
        clr_d       = clr_q + ROW_W'(1);
      end
      KVT_IDLE: begin
        s_axis_tready = !m_valid_q || m_axis_tready;
      end
      KVT_UPDATE: begin
        mem_wr_en = dec.wr_en;
        load_out  = 1'b1;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (load_out && dec.count_inc) begin
      count_d = count_q + CNT_W'(1);
    end else if (load_out && dec.count_dec) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  if (CNT_W > COUNT_FW) begin : g_sat
    assign count_sat = (count_d > CNT_W'(COUNT_MAX)) ? COUNT_FW'(COUNT_MAX)
                                                     : count_d[COUNT_FW-1:0];
  end else begin : g_nosat
    assign count_sat = COUNT_FW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= KVT_CLEAR;
      clr_q     <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      count_q <= count_d;
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // hold the request for the update cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= kvt_cmd_e'(s_axis_tuser);
      key_q   <= KEY_WIDTH'(s_axis_tdata[BUCKET_W +: KEY_FW]);
      value_q <= VALUE_WIDTH'(s_axis_tdata[BUCKET_W + KEY_FW +: VALUE_FW]);
      row_q   <= in_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= dec.status;
      out_found_q  <= found;
      out_count_q  <= count_sat;
      out_empty_q  <= (count_d == '0);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {(OUT_DATA_W - VALUE_FW - COUNT_FW - 1)'(0),
                          out_empty_q, out_count_q, out_found_q};

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == KVT_CLEAR |-> !s_axis_tready)
    else $error("request accepted during clearing pass");

  a_accept_to_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == KVT_UPDATE)
    else $error("accepted request not followed by update cycle");

  a_result_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == KVT_UPDATE)
    else $error("result raised without an update cycle");

  a_count_only_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != KVT_UPDATE |=> $stable(count_q))
    else $error("entry count changed outside an update cycle");

  a_single_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dec.count_inc && dec.count_dec))
    else $error("entry count stepped both ways at once");

endmodule

@@ rtl/kvt_row_mem.sv @@
`timescale 1ns / 1ps
// Bucket row memory: one write port, one registered read port.
// Depends on kvt_pkg.
module kvt_row_mem import kvt_pkg::*; #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned WIDTH  = 520
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/kvt_bucket_logic.sv @@
`timescale 1ns / 1ps
// Bucket row compare and update: parallel key match, first free way, new row.
// Depends on kvt_pkg.
module kvt_bucket_logic import kvt_pkg::*; #(
  parameter int unsigned WAYS        = 8,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned ROW_BITS    = 520
) (
  input  kvt_cmd_e                 cmd_i,
  input  logic [KEY_WIDTH-1:0]     key_i,
  input  logic [VALUE_WIDTH-1:0]   value_i,
  input  logic [ROW_BITS-1:0]      row_i,
  output logic [ROW_BITS-1:0]      row_o,
  output logic [VALUE_FW-1:0]      found_o,
  output kvt_decision_t            dec_o
);

  localparam int unsigned KEY_BASE   = WAYS;
  localparam int unsigned VALUE_BASE = WAYS + WAYS * KEY_WIDTH;

  logic [WAYS-1:0]        valid;
  logic [WAYS-1:0]        hit_vec;
  logic [WAYS-1:0]        free_vec;
  logic [WAYS-1:0]        first_hit;
  logic [WAYS-1:0]        first_free;
  logic                   any_hit;
  logic                   any_free;
  logic                   do_insert;
  logic                   do_remove;
  logic [VALUE_WIDTH-1:0] found_raw;

  always_comb begin
    valid     = row_i[WAYS-1:0];
    found_raw = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = valid[w] && (row_i[KEY_BASE + w*KEY_WIDTH +: KEY_WIDTH] == key_i);
    end
    free_vec   = ~valid;
    first_hit  = hit_vec & (~hit_vec + WAYS'(1));
    first_free = free_vec & (~free_vec + WAYS'(1));
    any_hit    = |hit_vec;
    any_free   = |free_vec;
    for (int w = 0; w < WAYS; w++) begin
      found_raw = found_raw |
                  (row_i[VALUE_BASE + w*VALUE_WIDTH +: VALUE_WIDTH] & {VALUE_WIDTH{first_hit[w]}});
    end
  end

  always_comb begin
    dec_o     = '{wr_en: 1'b0, count_inc: 1'b0, count_dec: 1'b0, status: KVT_OK};
    do_insert = 1'b0;
    do_remove = 1'b0;
    found_o   = '0;
    unique case (cmd_i)
      KVT_INSERT: begin
        if (any_hit) begin
          dec_o.status = KVT_PRESENT;
        end else if (!any_free) begin
          dec_o.status = KVT_FULL;
        end else begin
          do_insert       = 1'b1;
          dec_o.wr_en     = 1'b1;
          dec_o.count_inc = 1'b1;
        end
      end
      KVT_FIND: begin
        if (any_hit) begin
          found_o = VALUE_FW'(found_raw);
        end else begin
          dec_o.status = KVT_MISSING;
        end
      end
      KVT_REMOVE: begin
        if (any_hit) begin
          do_remove       = 1'b1;
          dec_o.wr_en     = 1'b1;
          dec_o.count_dec = 1'b1;
        end else begin
          dec_o.status = KVT_MISSING;
        end
      end
      default: begin
        dec_o.status = KVT_OK;
      end
    endcase
  end

  always_comb begin
    row_o = row_i;
    for (int w = 0; w < WAYS; w++) begin
      if (do_insert && first_free[w]) begin
        row_o[w]                                           = 1'b1;
        row_o[KEY_BASE + w*KEY_WIDTH +: KEY_WIDTH]         = key_i;
        row_o[VALUE_BASE + w*VALUE_WIDTH +: VALUE_WIDTH]   = value_i;
      end
      if (do_remove && first_hit[w]) begin
        row_o[w] = 1'b0;
      end
    end
  end

endmodule

@@ verif/kvt_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the chained hash key-value table: watches both stream channels,
// predicts each result from its own copy of the bucket slots and compares them.
// Depends on kvt_pkg for field widths, command and status codes.
module kvt_checker import kvt_pkg::*; #(
  parameter int unsigned BUCKETS = 256,
  parameter int unsigned WAYS    = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  // bucket [7:0], key [39:8], value [71:40]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // command [1:0]
  input  logic [1:0]            s_axis_tuser_i,
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  // found_value [31:0], entry_count [43:32], is_empty [44]
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  // status [1:0]
  input  logic [1:0]            m_axis_tuser_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int unsigned SLOTS = BUCKETS * WAYS;

  typedef struct packed {
    kvt_status_e           status;
    logic [VALUE_FW-1:0]   found_value;
    logic [COUNT_FW-1:0]   entry_count;
    logic                  is_empty;
  } kvt_result_t;

  logic                slot_used  [SLOTS];
  logic [KEY_FW-1:0]   slot_key   [SLOTS];
  logic [VALUE_FW-1:0] slot_value [SLOTS];
  int unsigned         stored_entries;
  kvt_result_t         expected_results[$];
  int                  mismatches;

  function automatic kvt_result_t apply_request(logic [1:0] cmd, logic [BUCKET_W-1:0] bucket,
                                                logic [KEY_FW-1:0] key,
                                                logic [VALUE_FW-1:0] value);
    kvt_result_t res;
    int          base;
    int          hit;
    int          free_way;
    base     = int'(bucket % BUCKETS) * WAYS;
    hit      = -1;
    free_way = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (slot_used[base + w]) begin
        if (hit < 0 && slot_key[base + w] == key) hit = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    res.status      = KVT_OK;
    res.found_value = '0;
    case (cmd)
      KVT_INSERT: begin
        if (hit >= 0) begin
          res.status = KVT_PRESENT;
        end else if (free_way < 0) begin
          res.status = KVT_FULL;
        end else begin
          slot_used[base + free_way]  = 1'b1;
          slot_key[base + free_way]   = key;
          slot_value[base + free_way] = value;
          stored_entries++;
        end
      end
      KVT_FIND: begin
        if (hit >= 0) res.found_value = slot_value[base + hit];
        else res.status = KVT_MISSING;
      end
      KVT_REMOVE: begin
        if (hit >= 0) begin
          slot_used[base + hit] = 1'b0;
          if (stored_entries > 0) stored_entries--;
        end else begin
          res.status = KVT_MISSING;
        end
      end
      default: ;
    endcase
    res.entry_count = (stored_entries > COUNT_MAX) ? COUNT_FW'(COUNT_MAX)
                                                   : COUNT_FW'(stored_entries);
    res.is_empty    = (stored_entries == 0);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    kvt_result_t got;
    kvt_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      stored_entries = 0;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.status      = kvt_status_e'(m_axis_tuser_i);
        got.found_value = m_axis_tdata_i[31:0];
        got.entry_count = m_axis_tdata_i[43:32];
        got.is_empty    = m_axis_tdata_i[44];
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with no request outstanding: status %0d value %h",
                     $realtime, got.status, got.found_value);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.found_value !== want.found_value ||
              got.entry_count !== want.entry_count || got.is_empty !== want.is_empty) begin
            if (mismatches < 10)
              $display("%0t: exp/act status %0d/%0d value %h/%h count %0d/%0d empty %0b/%0b",
                       $realtime,
                       want.status, got.status, want.found_value, got.found_value,
                       want.entry_count, got.entry_count, want.is_empty, got.is_empty);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_results.push_back(apply_request(s_axis_tuser_i, s_axis_tdata_i[7:0],
                                                 s_axis_tdata_i[39:8], s_axis_tdata_i[71:40]));
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_results.size();
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the chained hash key-value table: clock, reset, request
// stimulus and result back-pressure; checking is done by kvt_checker.
// Depends on kvt_pkg, chained_hash_key_value_table_top and kvt_checker.
module tb_top;
  import kvt_pkg::*;

  localparam logic [1:0] CMD_UNUSED       = 2'd3;
  localparam int         BUCKET_WAYS      = 8;
  localparam int         RANDOM_PER_PHASE = 650;
  localparam int         MAX_GAP          = 20;
  localparam int         POOL_SIZE        = 24;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;

  int                    send_idle_pct  = 0;
  int                    recv_stall_pct = 0;
  int                    fail_count;
  int                    pending_count;
  logic [KEY_FW-1:0]     key_pool [POOL_SIZE];
  logic [BUCKET_W-1:0]   busy_buckets [4];

  chained_hash_key_value_table_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  kvt_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .fail_count_o    (fail_count),
    .pending_o       (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic send_request(input logic [1:0] cmd, input logic [BUCKET_W-1:0] bucket,
                              input logic [KEY_FW-1:0] key, input logic [VALUE_FW-1:0] value);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {value, key, bucket};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // mostly hot buckets and pooled keys so that hits, duplicates and full rows occur
  task automatic send_random_request();
    int                  pick;
    logic [1:0]          cmd;
    logic [BUCKET_W-1:0] bucket;
    logic [KEY_FW-1:0]   key;
    pick = $urandom_range(99);
    if (pick < 40) cmd = KVT_INSERT;
    else if (pick < 65) cmd = KVT_FIND;
    else if (pick < 95) cmd = KVT_REMOVE;
    else cmd = CMD_UNUSED;
    if ($urandom_range(99) < 70) bucket = busy_buckets[$urandom_range(3)];
    else bucket = BUCKET_W'($urandom);
    if ($urandom_range(99) < 80) key = key_pool[$urandom_range(POOL_SIZE - 1)];
    else key = $urandom;
    send_request(cmd, bucket, key, $urandom);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KVT_INSERT;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    busy_buckets[0] = '0;
    busy_buckets[1] = '1;
    busy_buckets[2] = BUCKET_W'($urandom);
    busy_buckets[3] = BUCKET_W'($urandom);
    send_idle_pct  = 10;
    recv_stall_pct = 57;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(KVT_FIND,   8'h00, 32'h0000_0000, 32'h1234_5678);
    send_request(KVT_REMOVE, 8'h00, 32'h0000_0000, 32'h0000_0000);
    send_request(CMD_UNUSED, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(KVT_INSERT, 8'h00, 32'h0000_0000, 32'h0000_0000);
    send_request(KVT_INSERT, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(KVT_FIND,   8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(KVT_FIND,   8'h00, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(KVT_INSERT, 8'h00, 32'h0000_0000, 32'h0000_0001);
    send_request(KVT_FIND,   8'hFF, 32'h0000_0000, 32'h0000_0000);
    send_request(KVT_INSERT, 8'hFF, 32'h0000_0000, 32'hA5A5_A5A5);
    for (int w = 0; w <= BUCKET_WAYS; w++)
      send_request(KVT_INSERT, 8'h5A, 32'h1000_0000 + w, 32'hC000_0000 + w);
    send_request(KVT_FIND,   8'h5A, 32'h1000_0003, 32'h0000_0000);
    send_request(KVT_REMOVE, 8'h5A, 32'h1000_0003, 32'h0000_0000);
    send_request(KVT_INSERT, 8'h5A, 32'h1000_0000 + BUCKET_WAYS, 32'h5A5A_5A5A);
    send_request(KVT_FIND,   8'h5A, 32'h1000_0000 + BUCKET_WAYS, 32'h0000_0000);
    send_request(KVT_REMOVE, 8'h00, 32'h0000_0000, 32'h0000_0000);
    send_request(KVT_REMOVE, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);

    repeat (RANDOM_PER_PHASE) send_random_request();
    send_idle_pct  = 57;
    recv_stall_pct = 10;
    repeat (RANDOM_PER_PHASE) send_random_request();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (RANDOM_PER_PHASE) send_random_request();

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
